### design/stir_pkg.sv
// Shared constants, request and response types, and control structs for the slot table.
package stir_pkg;

    localparam int NUM_GROUPS  = 4;
    localparam int GROUP_SLOTS = 16;
    localparam int KEY_BITS    = 48;

    localparam int GRP_W  = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int SLOT_W = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;

    localparam int KEY_IN_W    = 48;
    localparam int GROUP_IN_W  = 3;
    localparam int FOUND_GRP_W = 2;
    localparam int FOUND_SLT_W = 4;

    typedef enum logic
    {
        MODE_INSERT = 1'b0,
        MODE_REMOVE = 1'b1
    } mode_t;

    typedef struct packed
    {
        mode_t                 mode;
        logic [KEY_IN_W-1:0]   key;
        logic [GROUP_IN_W-1:0] group;
    } req_t;

    typedef struct packed
    {
        logic                   success;
        logic [FOUND_GRP_W-1:0] found_group;
        logic [FOUND_SLT_W-1:0] found_slot;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic load;
        logic scan;
        logic commit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed
    {
        logic hit;
        logic miss;
    } sts_t;

endpackage

### design/stir_ifs.sv
// Request and response channel interfaces with valid/ready handshake.
interface stir_req_if;
    import stir_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface stir_rsp_if;
    import stir_pkg::*;

    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### design/stir_ctrl.sv
// Controller state machine for the slot table: accept, scan, commit and respond.
module stir_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    input  stir_pkg::sts_t sts,
    output stir_pkg::cmd_t cmd
);
    import stir_pkg::*;

    typedef enum logic [2:0]
    {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_vld_reg;
    logic   out_vld_next;
    logic   out_free;
    logic   scan_end;

    assign out_free  = !out_vld_reg || rsp_ready;
    assign scan_end  = sts.hit || sts.miss;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_vld_reg;

    always_comb
    begin
        state_next   = state_reg;
        out_vld_next = out_vld_reg && !rsp_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.commit   = 1'b1;
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

`ifndef SYNTH
    // The end of a scan always hands over to the commit state.
    a_scan_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && scan_end) |=> (state_reg == ST_DONE))
        else $error("scan ended without moving to commit");

    // A response only appears after a commit.
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg == ST_DONE))
        else $error("response raised outside commit");

    // A commit with room at the output returns to idle with a response pending.
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> (state_reg == ST_IDLE && out_vld_reg))
        else $error("commit did not produce a response");

    // The datapath never reports a hit and a miss together.
    a_hit_miss: assert property (@(posedge clk) disable iff (!rst_n)
        !(sts.hit && sts.miss))
        else $error("hit and miss reported together");
`endif

endmodule

### design/stir_dp.sv
// Datapath for the slot table: valid bits, key memory, scan pipeline and response register.
module stir_dp
(
    input  logic           clk,
    input  logic           rst_n,
    input  stir_pkg::req_t req,
    input  stir_pkg::cmd_t cmd,
    output stir_pkg::sts_t sts,
    output stir_pkg::rsp_t rsp
);
    import stir_pkg::*;

    logic [NUM_GROUPS-1:0][GROUP_SLOTS-1:0] valid_reg;
    logic [KEY_BITS-1:0]                    key_mem [NUM_GROUPS][GROUP_SLOTS];

    logic [KEY_BITS-1:0] key_reg;
    mode_t               mode_reg;
    logic                bad_reg;

    // Issue stage: address of the entry being read.
    logic [GRP_W-1:0]  iss_grp_reg;
    logic [SLOT_W-1:0] iss_slot_reg;
    logic              iss_act_reg;
    logic              iss_last;

    // Compare stage: entry whose stored key is in key_rd_reg.
    logic [GRP_W-1:0]    cmp_grp_reg;
    logic [SLOT_W-1:0]   cmp_slot_reg;
    logic                cmp_vld_reg;
    logic                cmp_last_reg;
    logic [KEY_BITS-1:0] key_rd_reg;

    logic cmp_valid_bit;
    logic match;
    logic group_ok;
    rsp_t rsp_reg;

    assign group_ok = (req.group != '0) && (int'(req.group) <= NUM_GROUPS);

    // An insert scans only its own group; a remove runs through every group.
    assign iss_last = (iss_slot_reg == SLOT_W'(GROUP_SLOTS - 1))
                   && ((mode_reg == MODE_INSERT) || (iss_grp_reg == GRP_W'(NUM_GROUPS - 1)));

    assign cmp_valid_bit = valid_reg[cmp_grp_reg][cmp_slot_reg];
    assign match = (mode_reg == MODE_INSERT) ? !cmp_valid_bit
                                             : (cmp_valid_bit && (key_rd_reg == key_reg));

    assign sts.hit  = cmp_vld_reg && match;
    assign sts.miss = bad_reg || (cmp_vld_reg && !match && cmp_last_reg);
    assign rsp      = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            bad_reg     <= 1'b0;
            iss_act_reg <= 1'b0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                bad_reg     <= (req.mode == MODE_INSERT) && !group_ok;
                iss_act_reg <= (req.mode == MODE_REMOVE) || group_ok;
                cmp_vld_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                iss_act_reg <= iss_act_reg && !iss_last;
                cmp_vld_reg <= iss_act_reg;
            end
            else if (cmd.commit)
            begin
                bad_reg     <= 1'b0;
                iss_act_reg <= 1'b0;
                cmp_vld_reg <= 1'b0;
                if (sts.hit)
                begin
                    valid_reg[cmp_grp_reg][cmp_slot_reg] <= (mode_reg == MODE_INSERT);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg      <= KEY_BITS'(req.key);
            mode_reg     <= req.mode;
            iss_slot_reg <= '0;
            iss_grp_reg  <= (req.mode == MODE_INSERT) ? GRP_W'(req.group - 3'd1) : '0;
        end
        else if (cmd.scan && iss_act_reg)
        begin
            key_rd_reg   <= key_mem[iss_grp_reg][iss_slot_reg];
            cmp_grp_reg  <= iss_grp_reg;
            cmp_slot_reg <= iss_slot_reg;
            cmp_last_reg <= iss_last;
            if (iss_slot_reg == SLOT_W'(GROUP_SLOTS - 1))
            begin
                iss_slot_reg <= '0;
                if (!iss_last)
                begin
                    iss_grp_reg <= iss_grp_reg + 1'b1;
                end
            end
            else
            begin
                iss_slot_reg <= iss_slot_reg + 1'b1;
            end
        end

        if (cmd.commit && sts.hit && (mode_reg == MODE_INSERT))
        begin
            key_mem[cmp_grp_reg][cmp_slot_reg] <= key_reg;
        end

        if (cmd.commit)
        begin
            rsp_reg.success     <= sts.hit;
            rsp_reg.found_group <= sts.hit ? FOUND_GRP_W'(cmp_grp_reg) : '0;
            rsp_reg.found_slot  <= sts.hit ? FOUND_SLT_W'(cmp_slot_reg) : '0;
        end
    end

endmodule

### design/slot_table_insert_remove_top.sv
// Top level of the slot table: first-free insert into a group and remove by key.
// Each item passes through an accept state, a scan that reads the key memory for each
// entry in the issue and compare stages, and a commit state that loads the response.
// Throughput: one request at a time; an insert scans at most GROUP_SLOTS entries, a
// remove up to all NUM_GROUPS*GROUP_SLOTS, set by the single read port of the key memory.
// Reset: asynchronous, active low; it empties every slot at once and clears the handshake.
module slot_table_insert_remove_top
(
    input  logic       clk,
    input  logic       rst_n,
    stir_req_if.sink   item,
    stir_rsp_if.source result
);
    import stir_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic item_ready;
    logic result_valid;
    rsp_t result_payload;

    // The controller sequences each request: it accepts only when idle, lets the datapath
    // scan until a hit or the end of the range, and then commits the table update together
    // with loading the response register. A new request can be accepted while the previous
    // response is still waiting at the output.
    stir_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (item.valid),
        .req_ready (item_ready),
        .rsp_valid (result_valid),
        .rsp_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds the valid bits, the key memory, and the two-stage scan pipeline.
    stir_dp u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (item.payload),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (result_payload)
    );

    assign item.ready     = item_ready;
    assign result.valid   = result_valid;
    assign result.payload = result_payload;

endmodule
